### rtl/core/assert_macros.svh
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SPSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spsc assertion failed");
`define SPSC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("spsc assertion failed");
`else
`define SPSC_ASSERT(lbl, clk, rst, prop)
`define SPSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/core/spsc_pkg.sv
package spsc_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned POT_W    = 10;
   localparam int unsigned PERIOD_W = 11;
   localparam int unsigned PRESS_W  = 16;

   localparam logic [POT_W-1:0]    POT_LOW          = 10'd10;
   localparam logic [POT_W-1:0]    POT_HIGH         = 10'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_SLOW      = 11'd2000;
   localparam logic [PERIOD_W-1:0] PERIOD_FAST      = 11'd300;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 11'd1000;
   localparam logic [PRESS_W-1:0]  LONG_PRESS_RESET = 16'd800;

   // (pot-10)*1700/990 == ((pot-10) * 170 * ceil(2^24/99)) >> 24 over the pot range
   localparam int unsigned SPAN_MUL_W = 25;
   localparam int unsigned SPAN_SHIFT = 24;
   localparam logic [SPAN_MUL_W-1:0] SPAN_MUL = 25'd28809390;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 48;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_TICK   = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [TIME_W-1:0]   time_value;
      logic [POT_W-1:0]    pot_value;
      logic                button_level;
   } in_word_type;

   typedef struct packed {
      logic                in_range;
      logic [PERIOD_W-1:0] period;
   } speed_type;

   typedef struct packed {
      logic                motor_on;
      logic                dir_cw;
      logic [PERIOD_W-1:0] half_period;
   } panel_state_type;

   typedef struct packed {
      logic                step_level;
      logic [TIME_W-1:0]   step_total;
   } pulse_state_type;

endpackage

### rtl/core/spsc_speed.sv
module spsc_speed
   import spsc_pkg::*;
(
   input  logic [POT_W-1:0] pot_value,
   output speed_type        speed
);

   logic [POT_W-1:0]                offset;
   logic [POT_W+SPAN_MUL_W-1:0]     product;
   logic [PERIOD_W-1:0]             drop;

   assign offset  = pot_value - POT_LOW;
   assign product = {{SPAN_MUL_W{1'b0}}, offset} * {{POT_W{1'b0}}, SPAN_MUL};
   assign drop    = product[SPAN_SHIFT +: PERIOD_W];

   assign speed.in_range = (pot_value > POT_LOW) && (pot_value < POT_HIGH);
   assign speed.period   = PERIOD_SLOW - drop;

endmodule

### rtl/core/spsc_panel.sv
module spsc_panel
   import spsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [PRESS_W-1:0]  csr_wr_data,
   input  logic                sample_en,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic                button_level,
   input  speed_type           speed,
   output panel_state_type     state
);

   logic [PRESS_W-1:0]  long_press_ff, long_press_in;
   logic                motor_on_ff, motor_on_in;
   logic                dir_cw_ff, dir_cw_in;
   logic                prev_button_ff, prev_button_in;
   logic [TIME_W-1:0]   press_start_ff, press_start_in;
   logic [PERIOD_W-1:0] half_period_ff, half_period_in;
   logic [TIME_W-1:0]   held;
   logic                is_long;

   assign held    = now_ms - press_start_ff;
   assign is_long = held >= {{(TIME_W-PRESS_W){1'b0}}, long_press_ff};

   always_comb begin
      long_press_in  = csr_wr_en ? csr_wr_data : long_press_ff;
      motor_on_in    = motor_on_ff;
      dir_cw_in      = dir_cw_ff;
      prev_button_in = prev_button_ff;
      press_start_in = press_start_ff;
      half_period_in = half_period_ff;
      if (sample_en) begin
         if (prev_button_ff && !button_level) begin
            press_start_in = now_ms;
         end
         if (!prev_button_ff && button_level) begin
            if (is_long) begin
               motor_on_in = !motor_on_ff;
            end else begin
               dir_cw_in = !dir_cw_ff;
            end
         end
         prev_button_in = button_level;
         // enable after this sample's release decides
         if (motor_on_in && speed.in_range) begin
            half_period_in = speed.period;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff  <= LONG_PRESS_RESET;
         motor_on_ff    <= 1'b1;
         dir_cw_ff      <= 1'b1;
         prev_button_ff <= 1'b1;
         press_start_ff <= '0;
         half_period_ff <= PERIOD_RESET;
      end else begin
         long_press_ff  <= long_press_in;
         motor_on_ff    <= motor_on_in;
         dir_cw_ff      <= dir_cw_in;
         prev_button_ff <= prev_button_in;
         press_start_ff <= press_start_in;
         half_period_ff <= half_period_in;
      end
   end

   assign state.motor_on    = motor_on_ff;
   assign state.dir_cw      = dir_cw_ff;
   assign state.half_period = half_period_ff;

endmodule

### rtl/core/spsc_pulse.sv
module spsc_pulse
   import spsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              tick_en,
   input  logic [TIME_W-1:0] now_us,
   input  panel_state_type   panel,
   output pulse_state_type   state
);

   logic              level_ff, level_in;
   logic [TIME_W-1:0] last_toggle_ff, last_toggle_in;
   logic [TIME_W-1:0] edge_count_ff, edge_count_in;
   logic [TIME_W-1:0] elapsed;
   logic              due;

   assign elapsed = now_us - last_toggle_ff;
   assign due     = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, panel.half_period};

   always_comb begin
      level_in       = level_ff;
      last_toggle_in = last_toggle_ff;
      edge_count_in  = edge_count_ff;
      if (tick_en && panel.motor_on && due) begin
         level_in       = !level_ff;
         last_toggle_in = now_us;
         if (!level_ff) begin
            edge_count_in = edge_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= 1'b0;
         last_toggle_ff <= '0;
         edge_count_ff  <= '0;
      end else begin
         level_ff       <= level_in;
         last_toggle_ff <= last_toggle_in;
         edge_count_ff  <= edge_count_in;
      end
   end

   assign state.step_level = level_ff;
   assign state.step_total = edge_count_ff;

endmodule

### rtl/core/stepper_pulse_speed_controller_unit.sv
// Flow: an accepted word loads the input register, then the panel and pulse
// state registers update from it when the output can advance; the state registers
// double as the result register. One word per clock unless rsp_tready stalls.
// Reset: synchronous, active high; step low, count zero, motor enabled,
// clockwise, half-period 1000 us, long press 800 ms.
`include "assert_macros.svh"

module stepper_pulse_speed_controller_unit
   import spsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [PRESS_W-1:0]    csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // time_value[31:0], pot_value[41:32], button_level[42], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // step_level[0], dir_level[1], enable_n[2], step_total[34:3],
   // half_period_us[45:35], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   in_word_type     in_word_ff, in_word_in;
   logic            in_vld_ff, in_vld_in;
   logic            rsp_vld_ff, rsp_vld_in;
   logic            advance;
   logic            do_item;
   speed_type       speed;
   panel_state_type panel;
   pulse_state_type pulse;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || advance;
   assign do_item    = in_vld_ff && advance;

   always_comb begin
      in_word_in = in_word_ff;
      in_vld_in  = in_vld_ff;
      rsp_vld_in = rsp_vld_ff;
      if (req_tready) begin
         in_vld_in               = req_tvalid;
         in_word_in.kind         = kind_type'(req_tuser);
         in_word_in.time_value   = req_tdata[TIME_W-1:0];
         in_word_in.pot_value    = req_tdata[TIME_W +: POT_W];
         in_word_in.button_level = req_tdata[TIME_W+POT_W];
      end
      if (advance) begin
         rsp_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   spsc_speed u_speed (
      .pot_value (in_word_ff.pot_value),
      .speed     (speed)
   );

   spsc_panel u_panel (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .sample_en    (do_item && (in_word_ff.kind == KIND_SAMPLE)),
      .now_ms       (in_word_ff.time_value),
      .button_level (in_word_ff.button_level),
      .speed        (speed),
      .state        (panel)
   );

   spsc_pulse u_pulse (
      .clock   (clock),
      .reset   (reset),
      .tick_en (do_item && (in_word_ff.kind == KIND_TICK)),
      .now_us  (in_word_ff.time_value),
      .panel   (panel),
      .state   (pulse)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PERIOD_W-TIME_W-3){1'b0}},
                        panel.half_period,
                        pulse.step_total,
                        !panel.motor_on,
                        panel.dir_cw,
                        pulse.step_level};

   `SPSC_ASSERT(a_period_range, clock, reset,
      (panel.half_period >= PERIOD_FAST) && (panel.half_period <= PERIOD_SLOW))
   `SPSC_ASSERT(a_count_on_rise, clock, reset,
      (pulse.step_total != $past(pulse.step_total)) |->
         (pulse.step_level && !$past(pulse.step_level) && $past(do_item)))
   `SPSC_ASSERT(a_held_stage, clock, reset,
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_word_ff)))
   `SPSC_ASSERT(a_state_frozen, clock, reset,
      !do_item |=> ($stable(pulse) && $stable(panel.motor_on) && $stable(panel.dir_cw)))

endmodule
